// ----- rtl/bmec_pkg.sv -----
// ----------------------------------------------------------------------------
// bmec_pkg
// Shared constants, types and the character decoder for the bracket match
// error counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmec_pkg;

    // sizes
    localparam int STACK_DEPTH = 1024;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W      = 8;
    localparam int TYPE_W      = 2;
    localparam int TALLY_W     = 16;
    localparam int SUM_W       = ((DEPTH_W > TALLY_W) ? DEPTH_W : TALLY_W) + 1;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // bracket characters
    localparam logic [CHAR_W-1:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQ     = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQ    = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE = 8'h3E;

    // bracket type codes kept on the stack
    localparam logic [TYPE_W-1:0] BT_PAREN = 2'd0;
    localparam logic [TYPE_W-1:0] BT_SQ    = 2'd1;
    localparam logic [TYPE_W-1:0] BT_CURLY = 2'd2;
    localparam logic [TYPE_W-1:0] BT_ANGLE = 2'd3;

    typedef struct packed {
        logic              is_open;
        logic              is_close;
        logic [TYPE_W-1:0] btype;
    } t_char_class;

    // stack shift control, from the control logic to the cell chain
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TYPE_W-1:0] push_type;
    } t_stack_ctl;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class r;
        r = '{is_open: 1'b0, is_close: 1'b0, btype: BT_PAREN};
        unique case (c)
            CH_OPEN_PAREN:  r = '{is_open: 1'b1, is_close: 1'b0, btype: BT_PAREN};
            CH_OPEN_SQ:     r = '{is_open: 1'b1, is_close: 1'b0, btype: BT_SQ};
            CH_OPEN_CURLY:  r = '{is_open: 1'b1, is_close: 1'b0, btype: BT_CURLY};
            CH_OPEN_ANGLE:  r = '{is_open: 1'b1, is_close: 1'b0, btype: BT_ANGLE};
            CH_CLOSE_PAREN: r = '{is_open: 1'b0, is_close: 1'b1, btype: BT_PAREN};
            CH_CLOSE_SQ:    r = '{is_open: 1'b0, is_close: 1'b1, btype: BT_SQ};
            CH_CLOSE_CURLY: r = '{is_open: 1'b0, is_close: 1'b1, btype: BT_CURLY};
            CH_CLOSE_ANGLE: r = '{is_open: 1'b0, is_close: 1'b1, btype: BT_ANGLE};
            default:        r = '{is_open: 1'b0, is_close: 1'b0, btype: BT_PAREN};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmec_if.sv -----
// ----------------------------------------------------------------------------
// bmec_if
// Valid/ready channels for character items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmec_in_if;
    logic                        valid;
    logic                        ready;
    logic [bmec_pkg::CHAR_W-1:0] char_code;
    logic                        char_present;
    logic                        last_of_sequence;

    modport source (output valid, output char_code, output char_present,
                    output last_of_sequence, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input last_of_sequence, output ready);
endinterface

interface bmec_out_if;
    logic                         valid;
    logic                         ready;
    logic [bmec_pkg::TALLY_W-1:0] error_total;
    logic                         stack_overflowed;

    modport source (output valid, output error_total, output stack_overflowed,
                    input ready);
    modport sink   (input valid, input error_total, input stack_overflowed,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/bmec_cell.sv -----
// ----------------------------------------------------------------------------
// bmec_cell
// One stack entry: takes the entry above on a push, the entry below on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bmec_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_push,
    input  wire logic                        i_pop,
    input  wire logic [bmec_pkg::TYPE_W-1:0] i_from_above,
    input  wire logic [bmec_pkg::TYPE_W-1:0] i_from_below,
    output logic      [bmec_pkg::TYPE_W-1:0] o_entry
);

    logic [bmec_pkg::TYPE_W-1:0] r_entry;
    logic [bmec_pkg::TYPE_W-1:0] n_entry;

    // shift direction select
    always_comb begin
        priority if (i_push) begin
            n_entry = i_from_above;
        end else if (i_pop) begin
            n_entry = i_from_below;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- rtl/bmec_stack.sv -----
// ----------------------------------------------------------------------------
// bmec_stack
// Shifting stack built as a row of cells; cell 0 always holds the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bmec_stack (
    input  wire logic                        i_clk,
    input  wire bmec_pkg::t_stack_ctl        i_ctl,
    output logic      [bmec_pkg::TYPE_W-1:0] o_top
);

    logic [bmec_pkg::TYPE_W-1:0] entries [bmec_pkg::STACK_DEPTH];

    // chain of cells, neighbor to neighbor
    for (genvar k = 0; k < bmec_pkg::STACK_DEPTH; k++) begin : g_cell
        logic [bmec_pkg::TYPE_W-1:0] above;
        logic [bmec_pkg::TYPE_W-1:0] below;

        if (k == 0) begin : g_head
            assign above = i_ctl.push_type;
        end else begin : g_mid_up
            assign above = entries[k-1];
        end

        if (k == bmec_pkg::STACK_DEPTH - 1) begin : g_tail
            assign below = entries[k];
        end else begin : g_mid_dn
            assign below = entries[k+1];
        end

        bmec_cell u_cell (
            .i_clk        (i_clk),
            .i_push       (i_ctl.push),
            .i_pop        (i_ctl.pop),
            .i_from_above (above),
            .i_from_below (below),
            .o_entry      (entries[k])
        );
    end

    assign o_top = entries[0];

endmodule

`default_nettype wire

// ----- rtl/bracket_match_error_counter_unit.sv -----
// ----------------------------------------------------------------------------
// bracket_match_error_counter_unit
// Counts bracket mismatches over a character sequence and reports the total
// with the unclosed openers on the last item of each sequence.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                      accepted when
//  i_item     in   char_code, char_present, last_of_sequence    valid && ready
//  o_result   out  error_total, stack_overflowed                valid && ready
//
//  one item per cycle while ready is high; each result is registered
//  the stack is a shifting row of cells with the top in cell 0, so a push or
//  a pop and the top compare all finish in the cycle the item is taken
//  results go through an output register backed by one skid entry; input
//  ready drops only while the skid entry is occupied
//  synchronous active-low reset clears depth, tally, flag and result valids;
//  stack contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_match_error_counter_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmec_in_if.sink    i_item,
    bmec_out_if.source o_result
);

    logic                          r_overflow;
    logic                          n_overflow;
    logic [bmec_pkg::DEPTH_W-1:0]  r_depth;
    logic [bmec_pkg::DEPTH_W-1:0]  n_depth;
    logic [bmec_pkg::TALLY_W-1:0]  r_tally;
    logic [bmec_pkg::TALLY_W-1:0]  n_tally;

    logic                          r_out_valid;
    logic [bmec_pkg::TALLY_W-1:0]  r_out_total;
    logic                          r_out_ovf;
    logic                          r_sk_valid;
    logic [bmec_pkg::TALLY_W-1:0]  r_sk_total;
    logic                          r_sk_ovf;

    logic                          accept;
    logic                          res_valid;
    logic                          out_free;
    bmec_pkg::t_char_class         cls;
    bmec_pkg::t_stack_ctl          stk_ctl;
    logic [bmec_pkg::TYPE_W-1:0]   top;
    logic                          is_full;
    logic                          is_empty;
    logic                          err_hit;
    logic [bmec_pkg::TALLY_W-1:0]  tally_upd;
    logic                          ovf_upd;
    logic [bmec_pkg::DEPTH_W-1:0]  depth_upd;
    logic [bmec_pkg::SUM_W-1:0]    sum;
    logic [bmec_pkg::TALLY_W-1:0]  res_total;

    assign accept = i_item.valid && i_item.ready;
    assign i_item.ready = !r_sk_valid;

    // decode the character
    always_comb begin
        cls = bmec_pkg::classify(i_item.char_code);
        if (!i_item.char_present) begin
            cls.is_open  = 1'b0;
            cls.is_close = 1'b0;
        end
    end

    assign is_full  = (r_depth == bmec_pkg::DEPTH_W'(bmec_pkg::STACK_DEPTH));
    assign is_empty = (r_depth == '0);

    // stack shift control
    always_comb begin
        stk_ctl.push      = accept && cls.is_open && !is_full;
        stk_ctl.pop       = accept && cls.is_close && !is_empty;
        stk_ctl.push_type = cls.btype;
    end

    bmec_stack u_stack (
        .i_clk (i_clk),
        .i_ctl (stk_ctl),
        .o_top (top)
    );

    // error tally, depth and overflow after this item's character
    always_comb begin
        err_hit   = cls.is_close && (is_empty || (top != cls.btype));
        tally_upd = (err_hit && (r_tally != bmec_pkg::TALLY_MAX))
                    ? r_tally + bmec_pkg::TALLY_W'(1) : r_tally;
        ovf_upd   = r_overflow || (cls.is_open && is_full);
        unique case ({stk_ctl.push, stk_ctl.pop})
            2'b10:   depth_upd = r_depth + bmec_pkg::DEPTH_W'(1);
            2'b01:   depth_upd = r_depth - bmec_pkg::DEPTH_W'(1);
            default: depth_upd = r_depth;
        endcase
    end

    // final total with unclosed openers, saturating
    always_comb begin
        sum = bmec_pkg::SUM_W'(tally_upd) + bmec_pkg::SUM_W'(depth_upd);
        res_total = (sum > bmec_pkg::SUM_W'(bmec_pkg::TALLY_MAX))
                    ? bmec_pkg::TALLY_MAX : sum[bmec_pkg::TALLY_W-1:0];
    end

    assign res_valid = accept && i_item.last_of_sequence;

    // sequence state next values
    always_comb begin
        n_tally    = r_tally;
        n_depth    = r_depth;
        n_overflow = r_overflow;
        if (accept) begin
            if (i_item.last_of_sequence) begin
                n_tally    = '0;
                n_depth    = '0;
                n_overflow = 1'b0;
            end else begin
                n_tally    = tally_upd;
                n_depth    = depth_upd;
                n_overflow = ovf_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally    <= '0;
            r_depth    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_tally    <= n_tally;
            r_depth    <= n_depth;
            r_overflow <= n_overflow;
        end
    end

    // output register with one skid entry
    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out_total <= r_sk_total;
                r_out_ovf   <= r_sk_ovf;
            end else if (res_valid) begin
                r_out_total <= res_total;
                r_out_ovf   <= ovf_upd;
            end
        end else if (res_valid) begin
            r_sk_total <= res_total;
            r_sk_ovf   <= ovf_upd;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.error_total      = r_out_total;
    assign o_result.stack_overflowed = r_out_ovf;

`ifndef SYNTHESIS
    // depth never passes the stack size
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= bmec_pkg::DEPTH_W'(bmec_pkg::STACK_DEPTH))
        else $error("stack depth beyond stack size");

    // the skid entry is used only behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    // last item of a sequence leaves a cleared state
    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> (r_depth == '0) && (r_tally == '0) && !r_overflow)
        else $error("sequence state not cleared after last item");

    // a last item always yields a pending result next cycle
    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> r_out_valid)
        else $error("result lost after last item");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket match error counter. A queue of
// character items (short directed sequences, then random bracket sequences)
// feeds a valid/ready driver. Each accepted item updates a bench-side bracket
// stack that predicts the result of every last item of a sequence. A monitor
// compares each accepted result with the oldest prediction. Both sides idle
// at random outside a calm window.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int IDLE_PCT   = 15;
    localparam int STALL_MAX  = 1000;
    localparam int SHOW_MAX   = 10;
    localparam int RAND_ITEMS = 375;
    localparam int CALM_START = 250;
    localparam int CALM_STOP  = 650;
    localparam int DRAIN_CYC  = 10;

    typedef struct packed {
        logic [bmec_pkg::CHAR_W-1:0] code;
        logic                        present;
        logic                        last;
    } t_char_item;

    typedef struct packed {
        logic [bmec_pkg::TALLY_W-1:0] total;
        logic                         overflowed;
    } t_verdict;

    typedef struct packed {
        logic                        opener;
        logic                        closer;
        logic [bmec_pkg::TYPE_W-1:0] kind;
    } t_bracket_class;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmec_in_if  item_if ();
    bmec_out_if result_if ();

    bracket_match_error_counter_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // clock
    always #5 i_clk = ~i_clk;

    t_char_item pending_items[$];
    t_verdict   expected_verdicts[$];
    t_char_item next_item;
    t_verdict   oldest_verdict;

    // bench copy of the bracket stack and counters
    logic [bmec_pkg::TYPE_W-1:0] shadow_stack [bmec_pkg::STACK_DEPTH];
    int unsigned                 shadow_fill;
    int unsigned                 shadow_tally;
    logic                        shadow_overflow;

    int unsigned cycle_count;
    int unsigned quiet_cycles;
    int unsigned fault_count;
    logic        calm;

    assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_STOP);

    // character classification
    function automatic t_bracket_class sort_char(input logic [bmec_pkg::CHAR_W-1:0] c);
        t_bracket_class b;
        b = '{opener: 1'b0, closer: 1'b0, kind: bmec_pkg::BT_PAREN};
        unique case (c)
            bmec_pkg::CH_OPEN_PAREN:
                b = '{opener: 1'b1, closer: 1'b0, kind: bmec_pkg::BT_PAREN};
            bmec_pkg::CH_OPEN_SQ:
                b = '{opener: 1'b1, closer: 1'b0, kind: bmec_pkg::BT_SQ};
            bmec_pkg::CH_OPEN_CURLY:
                b = '{opener: 1'b1, closer: 1'b0, kind: bmec_pkg::BT_CURLY};
            bmec_pkg::CH_OPEN_ANGLE:
                b = '{opener: 1'b1, closer: 1'b0, kind: bmec_pkg::BT_ANGLE};
            bmec_pkg::CH_CLOSE_PAREN:
                b = '{opener: 1'b0, closer: 1'b1, kind: bmec_pkg::BT_PAREN};
            bmec_pkg::CH_CLOSE_SQ:
                b = '{opener: 1'b0, closer: 1'b1, kind: bmec_pkg::BT_SQ};
            bmec_pkg::CH_CLOSE_CURLY:
                b = '{opener: 1'b0, closer: 1'b1, kind: bmec_pkg::BT_CURLY};
            bmec_pkg::CH_CLOSE_ANGLE:
                b = '{opener: 1'b0, closer: 1'b1, kind: bmec_pkg::BT_ANGLE};
            default:
                b = '{opener: 1'b0, closer: 1'b0, kind: bmec_pkg::BT_PAREN};
        endcase
        return b;
    endfunction

    // character for a bracket kind, opening or closing
    function automatic logic [bmec_pkg::CHAR_W-1:0] bracket_char(
        input logic [bmec_pkg::TYPE_W-1:0] k,
        input logic                        closing
    );
        unique case (k)
            bmec_pkg::BT_PAREN:
                return closing ? bmec_pkg::CH_CLOSE_PAREN : bmec_pkg::CH_OPEN_PAREN;
            bmec_pkg::BT_SQ:
                return closing ? bmec_pkg::CH_CLOSE_SQ : bmec_pkg::CH_OPEN_SQ;
            bmec_pkg::BT_CURLY:
                return closing ? bmec_pkg::CH_CLOSE_CURLY : bmec_pkg::CH_OPEN_CURLY;
            default:
                return closing ? bmec_pkg::CH_CLOSE_ANGLE : bmec_pkg::CH_OPEN_ANGLE;
        endcase
    endfunction

    // update the bench stack with one accepted item, queue a verdict on the last
    task automatic absorb_char(input t_char_item it);
        t_bracket_class b;
        int unsigned    sum;
        t_verdict       v;
        if (it.present) begin
            b = sort_char(it.code);
            if (b.opener) begin
                if (shadow_fill >= bmec_pkg::STACK_DEPTH) begin
                    shadow_overflow = 1'b1;
                end else begin
                    shadow_stack[shadow_fill] = b.kind;
                    shadow_fill++;
                end
            end else if (b.closer) begin
                if (shadow_fill == 0) begin
                    if (shadow_tally < bmec_pkg::TALLY_MAX) shadow_tally++;
                end else begin
                    shadow_fill--;
                    if (shadow_stack[shadow_fill] != b.kind &&
                        shadow_tally < bmec_pkg::TALLY_MAX)
                        shadow_tally++;
                end
            end
        end
        if (it.last) begin
            sum = shadow_tally + shadow_fill;
            if (sum > bmec_pkg::TALLY_MAX) sum = bmec_pkg::TALLY_MAX;
            v.total      = sum[bmec_pkg::TALLY_W-1:0];
            v.overflowed = shadow_overflow;
            expected_verdicts.push_back(v);
            shadow_fill     = 0;
            shadow_tally    = 0;
            shadow_overflow = 1'b0;
        end
    endtask

    task automatic push_char(input logic [bmec_pkg::CHAR_W-1:0] c, input logic present,
                             input logic last);
        t_char_item it;
        it.code    = c;
        it.present = present;
        it.last    = last;
        pending_items.push_back(it);
    endtask

    // one random sequence: well-formed, broken or plain noise
    task automatic add_random_sequence();
        logic [bmec_pkg::TYPE_W-1:0] open_kinds[$];
        logic [bmec_pkg::TYPE_W-1:0] k;
        int                          style;
        int                          len;
        int                          r;
        style = $urandom_range(99);
        len   = $urandom_range(18, 1);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (style >= 85 || r < 8) begin
                push_char(8'($urandom_range(255)), $urandom_range(99) >= 10, 1'b0);
            end else if (open_kinds.size() > 0 && r < 52) begin
                k = open_kinds.pop_back();
                if (style >= 60 && $urandom_range(3) == 0) k = 2'($urandom_range(3));
                push_char(bracket_char(k, 1'b1), 1'b1, 1'b0);
            end else if (style >= 60 && r < 58) begin
                push_char(bracket_char(2'($urandom_range(3)), 1'b1), 1'b1, 1'b0);
            end else begin
                k = 2'($urandom_range(3));
                open_kinds.push_back(k);
                push_char(bracket_char(k, 1'b0), 1'b1, 1'b0);
            end
        end
        if (style < 60) begin
            while (open_kinds.size() > 0)
                push_char(bracket_char(open_kinds.pop_back(), 1'b1), 1'b1, 1'b0);
        end
        // close on the last character or on an empty item
        if ($urandom_range(1) == 1) begin
            pending_items[$].last = 1'b1;
        end else begin
            push_char(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                next_item.code    = item_if.char_code;
                next_item.present = item_if.char_present;
                next_item.last    = item_if.last_of_sequence;
                absorb_char(next_item);
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_item = pending_items.pop_front();
                    item_if.valid            <= 1'b1;
                    item_if.char_code        <= next_item.code;
                    item_if.char_present     <= next_item.present;
                    item_if.last_of_sequence <= next_item.last;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_verdicts.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_MAX)
                        $display("unexpected result: total %0d overflow %0b",
                                 result_if.error_total, result_if.stack_overflowed);
                end else begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (result_if.error_total !== oldest_verdict.total ||
                        result_if.stack_overflowed !== oldest_verdict.overflowed) begin
                        fault_count++;
                        if (fault_count <= SHOW_MAX)
                            $display("mismatch: expected total %0d overflow %0b, got %0d %0b",
                                     oldest_verdict.total, oldest_verdict.overflowed,
                                     result_if.error_total, result_if.stack_overflowed);
                    end
                end
            end
            result_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // cycle count and stall watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int before_size;
        int random_count;

        i_rst_n                  = 1'b0;
        item_if.valid            = 1'b0;
        item_if.char_code        = '0;
        item_if.char_present     = 1'b0;
        item_if.last_of_sequence = 1'b0;
        result_if.ready          = 1'b0;
        cycle_count              = 0;
        quiet_cycles             = 0;
        fault_count              = 0;
        shadow_fill              = 0;
        shadow_tally             = 0;
        shadow_overflow          = 1'b0;

        // directed: empty sequence
        push_char(8'h00, 1'b0, 1'b1);
        // one matched pair
        push_char(bmec_pkg::CH_OPEN_PAREN, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_PAREN, 1'b1, 1'b1);
        // every opener and closer, properly nested
        push_char(bmec_pkg::CH_OPEN_PAREN, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_SQ, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_CURLY, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_ANGLE, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_ANGLE, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_CURLY, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_SQ, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_PAREN, 1'b1, 1'b1);
        // type mismatches
        push_char(bmec_pkg::CH_OPEN_PAREN, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_SQ, 1'b1, 1'b1);
        push_char(bmec_pkg::CH_OPEN_ANGLE, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_CLOSE_CURLY, 1'b1, 1'b1);
        // closer on an empty stack
        push_char(bmec_pkg::CH_CLOSE_ANGLE, 1'b1, 1'b1);
        // unclosed openers, final item with no character
        push_char(bmec_pkg::CH_OPEN_CURLY, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_SQ, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_PAREN, 1'b0, 1'b1);
        // absent characters and plain bytes are ignored
        push_char(bmec_pkg::CH_CLOSE_PAREN, 1'b0, 1'b0);
        push_char(8'h61, 1'b1, 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        push_char(8'h00, 1'b1, 1'b0);
        push_char(bmec_pkg::CH_OPEN_ANGLE, 1'b0, 1'b1);

        // random sequences
        random_count = 0;
        while (random_count < RAND_ITEMS) begin
            before_size = pending_items.size();
            add_random_sequence();
            random_count += pending_items.size() - before_size;
        end

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain stimulus, then outstanding results
        while (pending_items.size() > 0 || item_if.valid) @(posedge i_clk);
        while (expected_verdicts.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fault_count == 0 && expected_verdicts.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bmec_pkg.sv
rtl/bmec_if.sv
rtl/bmec_cell.sv
rtl/bmec_stack.sv
rtl/bracket_match_error_counter_unit.sv
verif/tb_top.sv
